[rtl/mpd_pkg.sv]
// Package for the minimum partition difference block.
// Holds sizing constants, payload structs and the controller/datapath interface.
// No dependencies.
package mpd_pkg;

  localparam int MAX_SUM    = 4095;
  localparam int VALUE_BITS = 8;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (MAX_SUM + WORD_BITS) / WORD_BITS;
  localparam int ADDR_BITS  = $clog2(NUM_WORDS);
  localparam int BIT_BITS   = $clog2(WORD_BITS);
  localparam int SUM_BITS   = 12;
  localparam int PROD_BITS  = 22;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [BIT_BITS-1:0]   bit_idx_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [11:0] min_difference;
    logic [21:0] best_product;
    logic        overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic decide;      // update total / overflow flag
    logic prime;       // first source read of the shift-OR pass
    logic shift_run;   // shift-OR pass in progress
    logic scan_start;  // set up the downward search
    logic scan_run;    // search in progress
    logic mul;         // form difference and product
    logic emit;        // load result register and clear the set
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic do_shift;    // element changes the bitset
    logic last;        // element closes the set
    logic ovf;         // set has overflowed
    logic shift_busy;  // reads or a write of the pass still in flight
    logic found;       // search hit this cycle
    logic out_free;    // result register can take a new result
  } dp_status_t;

endpackage

[rtl/mpd_datapath.sv]
// Datapath: reachable-sum bitset memory, word shift-OR pass, downward search,
// multiplier and result register. Depends on mpd_pkg.
module mpd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpd_pkg::in_item_t   in_item_i,
  input  logic                out_stall_i,
  input  mpd_pkg::dp_cmd_t    cmd_i,
  output mpd_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  output mpd_pkg::out_item_t  out_item_o
);
  import mpd_pkg::*;

  localparam int    ShamtBits = BIT_BITS + 1;
  localparam addr_t LastWord  = addr_t'(NUM_WORDS - 1);

  // Item and set state
  value_t value_q;
  logic   last_q;
  sum_t   total_q;
  logic   ovf_q;

  logic [SUM_BITS:0] sum_ext;
  logic              fits;
  logic              nonzero;
  logic              do_shift;
  logic              set_ovf;

  addr_t    k_off;
  bit_idx_t b_off;

  // Bitset memory with per-word valid bits
  word_t              mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_q;

  addr_t addr_a;
  addr_t addr_b;
  logic  b_live_d;
  word_t rd_a_q, rd_b_q;
  logic  a_ok_q, a_zero_q, b_ok_q, b_zero_q, b_live_q;
  word_t a_eff, b_eff;

  // Shift-OR pass
  addr_t idx_q;
  logic  issuing_q;
  logic  wr_pend_q;
  addr_t wr_idx_q;
  word_t hi_q;
  word_t lo_part;
  word_t wr_word;

  // Search
  sum_t     half;
  addr_t    start_word;
  bit_idx_t limit;
  addr_t    scan_q;
  addr_t    scan_tag_q;
  logic     scan_fresh_q, scan_pend_q, scan_first_q;
  word_t    mask;
  word_t    masked;
  bit_idx_t hib;
  logic     found;
  sum_t     j_q;

  // Result
  sum_t                 rest;
  logic [2*SUM_BITS-1:0] prod_full;
  logic [PROD_BITS-1:0] prod_q;
  sum_t                 diff_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;
  logic                 out_free;

  assign sum_ext  = {1'b0, total_q} + (SUM_BITS+1)'(value_q);
  assign fits     = sum_ext <= (SUM_BITS+1)'(MAX_SUM);
  assign nonzero  = value_q != '0;
  assign do_shift = !ovf_q && nonzero && fits;
  assign set_ovf  = !ovf_q && nonzero && !fits;

  assign k_off = addr_t'(value_q >> BIT_BITS);
  assign b_off = value_q[BIT_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_item_i.value[VALUE_BITS-1:0];
      last_q  <= in_item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.decide) begin
      if (do_shift) total_q <= total_q + sum_t'(value_q);
      if (set_ovf)  ovf_q   <= 1'b1;
    end
  end

  // Port A: destination word during the pass, search word afterwards.
  // Port B: source word idx - k - 1 (primed with the top source word).
  assign addr_a   = cmd_i.scan_run ? scan_q : idx_q;
  assign addr_b   = cmd_i.prime ? addr_t'(LastWord - k_off)
                                : addr_t'(idx_q - k_off - addr_t'(1));
  assign b_live_d = cmd_i.prime || (cmd_i.shift_run && issuing_q && (idx_q > k_off));

  always_ff @(posedge clk_i) begin
    rd_a_q   <= mem_q[addr_a];
    rd_b_q   <= mem_q[addr_b];
    a_ok_q   <= vld_q[addr_a];
    b_ok_q   <= vld_q[addr_b];
    a_zero_q <= addr_a == '0;
    b_zero_q <= addr_b == '0;
    if (wr_pend_q) mem_q[wr_idx_q] <= wr_word;
  end

  // an unwritten word reads as its reset value: only sum zero is set
  assign a_eff = a_ok_q ? rd_a_q : (a_zero_q ? word_t'(1) : '0);
  assign b_eff = !b_live_q ? '0 : (b_ok_q ? rd_b_q : (b_zero_q ? word_t'(1) : '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      b_live_q <= 1'b0;
    end else begin
      b_live_q <= b_live_d;
      if (cmd_i.emit) begin
        vld_q <= '0;
      end else if (wr_pend_q) begin
        vld_q[wr_idx_q] <= 1'b1;
      end
    end
  end

  // dest word i |= (src[i-k] << b) | (src[i-k-1] >> (W-b))
  assign lo_part = (b_off == '0) ? '0
                 : (b_eff >> (ShamtBits'(WORD_BITS) - ShamtBits'(b_off)));
  assign wr_word = a_eff | (hi_q << b_off) | lo_part;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_run) hi_q <= b_eff;
    if (cmd_i.shift_run) wr_idx_q <= idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      issuing_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else if (cmd_i.prime) begin
      idx_q     <= LastWord;
      issuing_q <= 1'b1;
      wr_pend_q <= 1'b0;
    end else if (cmd_i.shift_run) begin
      wr_pend_q <= issuing_q;
      if (issuing_q) begin
        if (idx_q == k_off) begin
          issuing_q <= 1'b0;
        end else begin
          idx_q <= idx_q - addr_t'(1);
        end
      end
    end else begin
      wr_pend_q <= 1'b0;
    end
  end

  // Search for the largest reachable sum not above total/2, one word a cycle.
  assign half       = total_q >> 1;
  assign start_word = addr_t'(half >> BIT_BITS);
  assign limit      = half[BIT_BITS-1:0];
  assign mask       = scan_first_q ? (~word_t'(0) >> (bit_idx_t'(WORD_BITS - 1) - limit))
                                   : ~word_t'(0);
  assign masked     = a_eff & mask;

  always_comb begin
    hib = '0;
    for (int n = 0; n < WORD_BITS; n++) begin
      if (masked[n]) hib = bit_idx_t'(n);
    end
  end

  assign found = cmd_i.scan_run && scan_pend_q && (masked != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= '0;
      scan_fresh_q <= 1'b0;
      scan_pend_q  <= 1'b0;
      scan_first_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_q       <= start_word;
      scan_fresh_q <= 1'b1;
      scan_pend_q  <= 1'b0;
    end else if (cmd_i.scan_run) begin
      scan_pend_q  <= 1'b1;
      scan_first_q <= scan_fresh_q;
      scan_fresh_q <= 1'b0;
      if (scan_q != '0) scan_q <= scan_q - addr_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run) scan_tag_q <= scan_q;
    if (found) j_q <= sum_t'({scan_tag_q, hib});
  end

  // Difference and product
  assign rest      = total_q - j_q;
  assign prod_full = j_q * rest;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_full[PROD_BITS-1:0];
      diff_q <= total_q - (j_q << 1);
    end
  end

  // Result register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_q.overflow       <= ovf_q;
      out_item_q.min_difference <= ovf_q ? '0 : diff_q;
      out_item_q.best_product   <= ovf_q ? '0 : prod_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.do_shift   = do_shift;
  assign status_o.last       = last_q;
  assign status_o.ovf        = ovf_q;
  assign status_o.shift_busy = issuing_q || wr_pend_q;
  assign status_o.found      = found;
  assign status_o.out_free   = out_free;

endmodule

[rtl/mpd_ctrl.sv]
// Controller state machine: sequences accept, shift-OR pass, search,
// multiply and result transfer. Depends on mpd_pkg.
module mpd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpd_pkg::dp_status_t status_i,
  output mpd_pkg::dp_cmd_t    cmd_o
);
  import mpd_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecide = 3'd1;
  localparam logic [2:0] StPrime  = 3'd2;
  localparam logic [2:0] StShift  = 3'd3;
  localparam logic [2:0] StFin    = 3'd4;
  localparam logic [2:0] StScan   = 3'd5;
  localparam logic [2:0] StMul    = 3'd6;
  localparam logic [2:0] StEmit   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        if (status_i.do_shift) begin
          state_d = StPrime;
        end else if (status_i.last) begin
          state_d = StFin;
        end else begin
          state_d = StIdle;
        end
      end
      StPrime: begin
        cmd_o.prime = 1'b1;
        state_d     = StShift;
      end
      StShift: begin
        cmd_o.shift_run = 1'b1;
        if (!status_i.shift_busy) state_d = status_i.last ? StFin : StIdle;
      end
      StFin: begin
        if (status_i.ovf) begin
          state_d = StEmit;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.found) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != StIdle;

endmodule

[rtl/min_partition_difference.sv]
// Minimum two-part partition difference of a set streamed one element per transfer.
// A fitting nonzero element runs the one-word-per-cycle shift-OR pass over the
// 64-word bitset memory (two read ports); a zero or ignored element skips the pass.
// Closing element adds a setup step, a downward search, a multiply and a result load
// (overflowed set: setup and load); the load waits on a held result.
// Reset (async, active low) leaves only sum zero reachable; each result clears the set.
module min_partition_difference (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mpd_pkg::out_item_t out_item_o
);
  import mpd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: one element at a time; input transfers only in idle.
  mpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Bitset memory, search, multiplier and result register. The result register
  // decouples the output: a new element can transfer while a result waits.
  mpd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // Overflowed sets report zero difference and product.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overflow |->
      out_item_o.min_difference == '0 && out_item_o.best_product == '0)
    else $error("overflow result with nonzero fields");

  // The shift-OR pass must be drained before a new element is taken.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !status.shift_busy)
    else $error("input ready while shift pass in flight");

  // A result is only loaded when the result register is free.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result loaded over a held result");

  // After a result the set restarts clean.
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> !status.ovf)
    else $error("overflow flag survived a result");

endmodule
